[hw/rtl/ppm_p6_to_rgba_decoder_top_macros.svh]
// ----------------------------------------------------------------------------
// PPM decoder assertion macros
// Shorthand for the concurrent checks on the decoder ports.
// ----------------------------------------------------------------------------
`ifndef PPM_P6_TO_RGBA_DECODER_TOP_MACROS_SVH
`define PPM_P6_TO_RGBA_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PPMD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication, disabled during reset.
`define PPMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

[hw/rtl/ppmd_pkg.sv]
// ----------------------------------------------------------------------------
// PPM decoder package
// Shared types, codes and constants of the P6 to RGBA decoder.
// ----------------------------------------------------------------------------
package ppmd_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);

    localparam logic [15:0] MAX_DIM_RST   = 16'd16384;
    localparam logic [34:0] MAX_BYTES_RST = 35'd268435456;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [31:0] MAXVAL_OK = 32'd255;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    localparam logic       CFG_MAX_DIM   = 1'b0;
    localparam logic       CFG_MAX_BYTES = 1'b1;

    localparam logic       KIND_PIXEL  = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    localparam int TDATA_W = 104;

    typedef enum logic [1:0] {
        ST_READY     = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_DIMS      = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        PH_MAGIC_P  = 4'd0,
        PH_MAGIC_6  = 4'd1,
        PH_W_SKIP   = 4'd2,
        PH_W_CMT    = 4'd3,
        PH_W_NUM    = 4'd4,
        PH_H_SKIP   = 4'd5,
        PH_H_CMT    = 4'd6,
        PH_H_NUM    = 4'd7,
        PH_M_SKIP   = 4'd8,
        PH_M_CMT    = 4'd9,
        PH_M_NUM    = 4'd10,
        PH_AFTER_CR = 4'd11,
        PH_DATA     = 4'd12,
        PH_DONE     = 4'd13,
        PH_FAIL     = 4'd14
    } t_phase;

    typedef enum logic [1:0] {
        SUB_SKIP = 2'd0,
        SUB_CMT  = 2'd1,
        SUB_NUM  = 2'd2
    } t_sub;

    typedef struct packed {
        logic        has_px;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        has_st;
        t_status     status;
        logic [31:0] width;
        logic [31:0] height;
    } t_evt;

    function automatic logic [1:0] ph_field(input t_phase ph);
        logic [1:0] f;
        f = 2'd0;
        unique case (ph)
            PH_H_SKIP, PH_H_CMT, PH_H_NUM: f = 2'd1;
            PH_M_SKIP, PH_M_CMT, PH_M_NUM: f = 2'd2;
            default:                       f = 2'd0;
        endcase
        return f;
    endfunction

    function automatic t_sub ph_sub(input t_phase ph);
        t_sub s;
        s = SUB_SKIP;
        unique case (ph)
            PH_W_CMT, PH_H_CMT, PH_M_CMT: s = SUB_CMT;
            PH_W_NUM, PH_H_NUM, PH_M_NUM: s = SUB_NUM;
            default:                      s = SUB_SKIP;
        endcase
        return s;
    endfunction

    function automatic t_phase ph_make(input logic [1:0] f, input t_sub s);
        logic [3:0] v;
        v = 4'd2 + {2'b00, f} + {1'b0, f, 1'b0} + {2'b00, s};
        return t_phase'(v);
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= 8'h09 && b <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

[hw/rtl/ppmd_front.sv]
// ----------------------------------------------------------------------------
// PPM decoder front end
// Parses the header, checks limits, groups data bytes into pixel events, adds end status.
// ----------------------------------------------------------------------------
module ppmd_front
    import ppmd_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_index,
    input  logic [34:0] i_cfg_data,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_eof,
    output logic        o_push,
    output t_evt        o_evt
);

    logic [15:0]           r_max_dim;
    logic [34:0]           r_max_bytes;
    t_phase                r_phase, p_phase, n_phase;
    logic [31:0]           r_acc, p_acc, n_acc;
    logic [31:0]           r_width, p_width, n_width;
    logic [31:0]           r_height, p_height, n_height;
    logic [COUNT_BITS-1:0] r_left, p_left, n_left;
    logic [1:0]            r_chan, p_chan, n_chan;
    logic [7:0]            r_red, p_red, n_red;
    logic [7:0]            r_green, p_green, n_green;
    t_status               r_err, p_err, n_err;
    logic [63:0]           r_prod;
    logic                  r_dims_ok;
    logic                  p_pixel;
    logic [35:0]           acc_x10;
    logic [3:0]            digit;
    t_status               st;

    assign digit   = i_byte[3:0];
    assign acc_x10 = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {32'd0, digit};

    always_ff @(posedge i_clk) begin
        r_prod    <= {32'd0, r_width} * {32'd0, r_height};
        r_dims_ok <= (r_width != 32'd0) && (r_height != 32'd0)
                  && (r_width <= {16'd0, r_max_dim}) && (r_height <= {16'd0, r_max_dim})
                  && (r_prod[63:33] == 31'd0) && (r_prod[32:0] <= r_max_bytes[34:2])
                  && ((r_prod >> COUNT_BITS) == 64'd0);
    end

    always_comb begin
        logic [1:0] fld;
        t_sub       sub;
        logic       go;
        fld      = ph_field(r_phase);
        sub      = ph_sub(r_phase);
        go       = 1'b0;
        p_phase  = r_phase;
        p_acc    = r_acc;
        p_width  = r_width;
        p_height = r_height;
        p_left   = r_left;
        p_chan   = r_chan;
        p_red    = r_red;
        p_green  = r_green;
        p_err    = r_err;
        p_pixel  = 1'b0;
        unique case (r_phase)
            PH_MAGIC_P: begin
                if (i_byte == CH_P) begin
                    p_phase = PH_MAGIC_6;
                end else begin
                    p_phase = PH_FAIL;
                    p_err   = ST_MALFORMED;
                end
            end
            PH_MAGIC_6: begin
                if (i_byte == CH_SIX) begin
                    p_phase = PH_W_SKIP;
                end else begin
                    p_phase = PH_FAIL;
                    p_err   = ST_MALFORMED;
                end
            end
            PH_W_SKIP, PH_W_CMT, PH_W_NUM, PH_H_SKIP, PH_H_CMT, PH_H_NUM,
            PH_M_SKIP, PH_M_CMT, PH_M_NUM: begin
                if (sub == SUB_CMT) begin
                    if (i_byte == CH_LF) begin
                        p_phase = ph_make(fld, SUB_SKIP);
                    end
                end else if (sub == SUB_NUM) begin
                    if (is_digit(i_byte)) begin
                        if (|acc_x10[35:32]) begin
                            p_phase = PH_FAIL;
                            p_err   = ST_MALFORMED;
                        end else begin
                            p_acc = acc_x10[31:0];
                        end
                    end else if (fld == 2'd0) begin
                        p_width = r_acc;
                        fld     = 2'd1;
                        go      = 1'b1;
                    end else if (fld == 2'd1) begin
                        p_height = r_acc;
                        fld      = 2'd2;
                        go       = 1'b1;
                    end else if (r_acc != MAXVAL_OK || !is_space(i_byte)) begin
                        p_phase = PH_FAIL;
                        p_err   = ST_MALFORMED;
                    end else if (!r_dims_ok) begin
                        p_phase = PH_FAIL;
                        p_err   = ST_DIMS;
                    end else begin
                        p_left  = r_prod[COUNT_BITS-1:0];
                        p_chan  = 2'd0;
                        p_phase = (i_byte == CH_CR) ? PH_AFTER_CR : PH_DATA;
                    end
                end else begin
                    go = 1'b1;
                end
                if (go) begin
                    if (is_space(i_byte)) begin
                        p_phase = ph_make(fld, SUB_SKIP);
                    end else if (i_byte == CH_HASH) begin
                        p_phase = ph_make(fld, SUB_CMT);
                    end else if (is_digit(i_byte)) begin
                        p_acc   = {28'd0, digit};
                        p_phase = ph_make(fld, SUB_NUM);
                    end else begin
                        p_phase = PH_FAIL;
                        p_err   = ST_MALFORMED;
                    end
                end
            end
            PH_AFTER_CR, PH_DATA: begin
                if (r_phase == PH_AFTER_CR) begin
                    p_phase = PH_DATA;
                end
                if (r_phase == PH_DATA || i_byte != CH_LF) begin
                    if (r_chan == 2'd0) begin
                        p_red  = i_byte;
                        p_chan = 2'd1;
                    end else if (r_chan == 2'd1) begin
                        p_green = i_byte;
                        p_chan  = 2'd2;
                    end else begin
                        p_pixel = 1'b1;
                        p_chan  = 2'd0;
                        p_left  = r_left - 1'b1;
                        if (r_left == {{(COUNT_BITS-1){1'b0}}, 1'b1}) begin
                            p_phase = PH_DONE;
                        end
                    end
                end
            end
            PH_DONE, PH_FAIL: begin
            end
            default: begin
                p_phase = PH_FAIL;
                p_err   = ST_MALFORMED;
            end
        endcase
    end

    always_comb begin
        if (p_phase == PH_DONE) begin
            st = ST_READY;
        end else if (p_phase == PH_FAIL && p_err == ST_DIMS) begin
            st = ST_DIMS;
        end else begin
            st = ST_MALFORMED;
        end
        o_push       = i_accept && (p_pixel || i_eof);
        o_evt.has_px = p_pixel;
        o_evt.red    = r_red;
        o_evt.green  = r_green;
        o_evt.blue   = i_byte;
        o_evt.has_st = i_eof;
        o_evt.status = st;
        o_evt.width  = (st == ST_MALFORMED) ? 32'd0 : p_width;
        o_evt.height = (st == ST_MALFORMED) ? 32'd0 : p_height;
    end

    always_comb begin
        if (i_eof) begin
            n_phase  = PH_MAGIC_P;
            n_acc    = 32'd0;
            n_width  = 32'd0;
            n_height = 32'd0;
            n_left   = '0;
            n_chan   = 2'd0;
            n_red    = 8'd0;
            n_green  = 8'd0;
            n_err    = ST_READY;
        end else begin
            n_phase  = p_phase;
            n_acc    = p_acc;
            n_width  = p_width;
            n_height = p_height;
            n_left   = p_left;
            n_chan   = p_chan;
            n_red    = p_red;
            n_green  = p_green;
            n_err    = p_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dim   <= MAX_DIM_RST;
            r_max_bytes <= MAX_BYTES_RST;
            r_phase     <= PH_MAGIC_P;
            r_acc       <= 32'd0;
            r_width     <= 32'd0;
            r_height    <= 32'd0;
            r_left      <= '0;
            r_chan      <= 2'd0;
            r_red       <= 8'd0;
            r_green     <= 8'd0;
            r_err       <= ST_READY;
        end else begin
            if (i_cfg_valid && i_cfg_index == CFG_MAX_DIM) begin
                r_max_dim <= i_cfg_data[15:0];
            end
            if (i_cfg_valid && i_cfg_index == CFG_MAX_BYTES) begin
                r_max_bytes <= i_cfg_data;
            end
            if (i_accept) begin
                r_phase  <= n_phase;
                r_acc    <= n_acc;
                r_width  <= n_width;
                r_height <= n_height;
                r_left   <= n_left;
                r_chan   <= n_chan;
                r_red    <= n_red;
                r_green  <= n_green;
                r_err    <= n_err;
            end
        end
    end

endmodule

[hw/rtl/ppmd_fifo.sv]
// ----------------------------------------------------------------------------
// PPM decoder event queue
// Short first-in first-out queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module ppmd_fifo
    import ppmd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_evt i_evt,
    input  logic i_pop,
    output t_evt o_evt,
    output logic o_empty,
    output logic o_full
);

    t_evt                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, r_rd;
    logic [FIFO_PTR_W:0]   r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign o_evt   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/ppmd_back.sv]
// ----------------------------------------------------------------------------
// PPM decoder output stage
// Turns queued events into pixel and status beats on the result stream.
// ----------------------------------------------------------------------------
module ppmd_back
    import ppmd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_evt               i_evt,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_tvalid,
    input  logic               i_tready,
    output logic [TDATA_W-1:0] o_tdata,
    output logic               o_tuser,
    output logic               o_tlast
);

    logic r_valid;
    logic r_second;
    t_evt r_evt;
    logic both, beat, advance, show_st;

    assign both    = r_evt.has_px && r_evt.has_st && !r_second;
    assign beat    = r_valid && i_tready;
    assign advance = !r_valid || (beat && !both);
    assign o_pop   = advance && !i_empty;
    assign show_st = r_second || !r_evt.has_px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (beat && both) begin
            r_second <= 1'b1;
        end else if (advance) begin
            r_valid  <= !i_empty;
            r_second <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_evt <= i_evt;
        end
    end

    always_comb begin
        o_tvalid = r_valid;
        o_tuser  = show_st ? KIND_STATUS : KIND_PIXEL;
        o_tlast  = show_st;
        if (show_st) begin
            o_tdata = {6'd0, r_evt.height, r_evt.width, r_evt.status, 32'd0};
        end else begin
            o_tdata = {6'd0, 64'd0, ST_READY, ALPHA_OPAQUE, r_evt.blue, r_evt.green,
                       r_evt.red};
        end
    end

endmodule

[hw/rtl/ppm_p6_to_rgba_decoder_top.sv]
// ----------------------------------------------------------------------------
// PPM P6 to RGBA decoder
// Streams a binary PPM file in and RGBA pixels plus a final status out.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Content
// s_*       in         i_s_tvalid/o_s_tready  file byte, tlast on final byte
// m_*       out        o_m_tvalid/i_m_tready  pixel or status beat
// cfg_*     in         i_cfg_valid/o_cfg_ready limit register writes
//
// One byte is taken per cycle while the event queue is not full.
// A final byte that also completes a pixel yields a pixel beat, then a status beat.
// The four-entry event queue lets input continue while the output is stalled.
// Reset is synchronous and restores both limits to their defaults.
// ----------------------------------------------------------------------------
module ppm_p6_to_rgba_decoder_top
    import ppmd_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [7:0]         i_s_tdata,   // data_byte
    input  logic               i_s_tlast,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    // red, green, blue, alpha, status, image_width, image_height, zero fill
    output logic [TDATA_W-1:0] o_m_tdata,
    output logic               o_m_tuser,   // kind
    output logic               o_m_tlast,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [34:0]        i_cfg_data
);

    logic accept, push, pop, empty, full;
    t_evt evt_in, evt_out;

    assign o_s_tready  = !full;
    assign accept      = i_s_tvalid && !full;
    assign o_cfg_ready = 1'b1;

    ppmd_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_byte      (i_s_tdata),
        .i_eof       (i_s_tlast),
        .o_push      (push),
        .o_evt       (evt_in)
    );

    ppmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (evt_in),
        .i_pop   (pop),
        .o_evt   (evt_out),
        .o_empty (empty),
        .o_full  (full)
    );

    ppmd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_evt    (evt_out),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tuser  (o_m_tuser),
        .o_tlast  (o_m_tlast)
    );

endmodule

[hw/rtl/ppmd_checker.sv]
// ----------------------------------------------------------------------------
// PPM decoder port checker
// Concurrent checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "ppm_p6_to_rgba_decoder_top_macros.svh"

module ppmd_checker
    import ppmd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_m_tvalid,
    input logic               i_m_tready,
    input logic [TDATA_W-1:0] o_m_tdata,
    input logic               o_m_tuser,
    input logic               o_m_tlast
);

    `PPMD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid)
    `PPMD_ASSERT_NOW(a_last_status, i_clk, i_rst_n, o_m_tvalid, o_m_tlast == o_m_tuser)
    `PPMD_ASSERT_NOW(a_alpha, i_clk, i_rst_n, o_m_tvalid && o_m_tuser == KIND_PIXEL, o_m_tdata[31:24] == ALPHA_OPAQUE)
    `PPMD_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_m_tvalid && o_m_tuser == KIND_STATUS, o_m_tdata[33:32] != 2'd3)

endmodule

bind ppm_p6_to_rgba_decoder_top ppmd_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
